/* hdl/ptac_pkg.sv */
// ----------------------------------------------------------------------------
// ptac_pkg
// Shared types, constants and helpers for the arc-lane projection core.
// ----------------------------------------------------------------------------
`default_nettype none
package ptac_pkg;

	// CORDIC depth and datapath widths
	localparam int CORDIC_STEPS_DEF = 24;
	localparam int XW = 44;   // vectoring x/y width
	localparam int ZW = 34;   // Q30 angle accumulator width
	localparam int AW = 24;   // working angle width, 2^-16 rad units

	localparam logic signed [AW-1:0] PI_Q     = 24'sd205887;
	localparam logic signed [AW-1:0] TWO_PI_Q = 24'sd411775;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [63:0]   INV_GAIN_Q20 = 64'sd636751;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Y    = 3'd1,
		REG_RADIUS      = 3'd2,
		REG_THETA_START = 3'd3,
		REG_THETA_SPAN  = 3'd4,
		REG_OFFSET_MIN  = 3'd5,
		REG_OFFSET_MAX  = 3'd6,
		REG_ELEVATION_A = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} pt_t;

	typedef struct packed {
		logic        [30:0] arc_length;
		logic signed [31:0] lateral_offset;
		logic signed [31:0] height;
		logic               center_hit;
	} res_t;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic        [30:0] radius;
		logic signed [19:0] theta_start;
		logic signed [19:0] theta_span;
		logic signed [31:0] offset_min;
		logic signed [31:0] offset_max;
		logic signed [31:0] elevation_a;
	} cfg_t;

	// One beat travelling down the CORDIC cell row
	typedef struct packed {
		logic                 valid;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [31:0]   pz;
		logic                 hit;
	} cell_t;

	// arctan(2^-i) in Q30 rad
	function automatic logic [30:0] atan_q30(input logic [4:0] i);
		logic [30:0] v;
		case (i)
			5'd0:  v = 31'd843314857;
			5'd1:  v = 31'd497837829;
			5'd2:  v = 31'd263043836;
			5'd3:  v = 31'd133525158;
			5'd4:  v = 31'd67021686;
			5'd5:  v = 31'd33543515;
			5'd6:  v = 31'd16775850;
			5'd7:  v = 31'd8388437;
			5'd8:  v = 31'd4194282;
			5'd9:  v = 31'd2097149;
			5'd10: v = 31'd1048575;
			5'd11: v = 31'd524287;
			5'd12: v = 31'd262143;
			5'd13: v = 31'd131071;
			5'd14: v = 31'd65535;
			5'd15: v = 31'd32767;
			5'd16: v = 31'd16383;
			5'd17: v = 31'd8191;
			5'd18: v = 31'd4095;
			5'd19: v = 31'd2047;
			5'd20: v = 31'd1023;
			5'd21: v = 31'd511;
			5'd22: v = 31'd255;
			5'd23: v = 31'd127;
			5'd24: v = 31'd63;
			5'd25: v = 31'd31;
			5'd26: v = 31'd15;
			5'd27: v = 31'd7;
			5'd28: v = 31'd3;
			5'd29: v = 31'd1;
			default: v = 31'd0;
		endcase
		return v;
	endfunction

	// Reduce an angle within two turns of zero into [-pi, pi]
	function automatic logic signed [AW-1:0] wrap_ang(input logic signed [AW-1:0] t);
		logic signed [AW-1:0] r;
		r = t;
		if (r < 0) r = r + TWO_PI_Q;
		if (r < 0) r = r + TWO_PI_Q;
		if (r >= TWO_PI_Q) r = r - TWO_PI_Q;
		if (r >= TWO_PI_Q) r = r - TWO_PI_Q;
		if (r > PI_Q) r = r - TWO_PI_Q;
		return r;
	endfunction

endpackage
`default_nettype wire

/* hdl/ptac_cell.sv */
// ----------------------------------------------------------------------------
// ptac_cell
// One CORDIC vectoring micro-rotation with its pipeline register.
// ----------------------------------------------------------------------------
`default_nettype none
module ptac_cell
	import ptac_pkg::*;
#(
	parameter int STEP = 0
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire cell_t din,
	output cell_t      dout
);

	localparam logic [4:0] IDX = 5'(STEP);
	localparam logic signed [ZW-1:0] ATAN = $signed({3'b000, atan_q30(IDX)});

	cell_t nxt;
	logic signed [XW-1:0] sx, sy;

	// Rotate toward the x axis
	always_comb begin
		nxt = din;
		sx = din.x >>> STEP;
		sy = din.y >>> STEP;
		if (din.y < 0) begin
			nxt.x = din.x - sy;
			nxt.y = din.y + sx;
			nxt.z = din.z - ATAN;
		end else begin
			nxt.x = din.x + sy;
			nxt.y = din.y - sx;
			nxt.z = din.z + ATAN;
		end
	end

	// Hand the beat to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end

endmodule
`default_nettype wire

/* hdl/ptac_post.sv */
// ----------------------------------------------------------------------------
// ptac_post
// Angle snapping, arc length, radial offset and height back end.
// ----------------------------------------------------------------------------
`default_nettype none
module ptac_post
	import ptac_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire cfg_t  cfg,
	input  wire cell_t din,
	output logic       res_valid,
	output res_t       res_data
);

	function automatic logic signed [AW-1:0] abs_a(input logic signed [AW-1:0] v);
		return (v < 0) ? -v : v;
	endfunction

	// ---- configuration-derived terms, registered behind the configuration and not held by en
	logic signed [AW-1:0] tmin_q, tmax_q, t0_q, t1_q;
	logic                 full_q;
	logic signed [35:0]   pscale_q;
	logic signed [51:0]   elev_hi_q;
	logic signed [32:0]   elev_lo_q;
	logic signed [53:0]   elev_q;
	logic signed [AW-1:0] ts_ext, te_ext;
	logic signed [51:0]   pprod;
	logic signed [48:0]   lo_prod;

	always_comb begin
		ts_ext  = AW'(cfg.theta_start);
		te_ext  = ts_ext + AW'(cfg.theta_span);
		pprod   = 52'($signed({1'b0, cfg.radius})) * 52'(cfg.theta_span);
		lo_prod = 49'(cfg.elevation_a) * 49'($signed({1'b0, pscale_q[15:0]}));
	end

	always_ff @(posedge clk) begin
		tmin_q    <= (te_ext < ts_ext) ? te_ext : ts_ext;
		tmax_q    <= (te_ext < ts_ext) ? ts_ext : te_ext;
		t0_q      <= wrap_ang(tmin_q);
		t1_q      <= wrap_ang(tmax_q);
		full_q    <= (tmax_q >= tmin_q + TWO_PI_Q);
		pscale_q  <= 36'((pprod + 52'sd32768) >>> 16);
		elev_hi_q <= 52'(cfg.elevation_a) * 52'($signed(pscale_q[35:16]));
		elev_lo_q <= 33'((lo_prod + 49'sd32768) >>> 16);
		elev_q    <= 54'(elev_hi_q) + 54'(elev_lo_q);
	end

	// ---- stage 1: angle rounding, magnitude, height
	logic                 v_s1, hit_s1;
	logic signed [19:0]   ang_s1;
	logic signed [35:0]   mag_s1;
	logic signed [31:0]   h_s1;
	logic signed [ZW:0]   zr;
	logic signed [20:0]   zt;
	logic signed [63:0]   magp;
	logic signed [53:0]   hd;
	logic signed [19:0]   ang_n;
	logic signed [31:0]   h_n;

	always_comb begin
		zr   = (ZW+1)'(din.z) + (ZW+1)'(8192);
		zt   = 21'(zr >>> 14);
		if (zt > 21'(PI_Q)) ang_n = 20'(PI_Q);
		else if (zt < -21'(PI_Q)) ang_n = -20'(PI_Q);
		else ang_n = 20'(zt);
		magp = 64'(din.x) * INV_GAIN_Q20;
		hd   = 54'(din.pz) - elev_q;
		if (hd > 54'sd2147483647) h_n = 32'sh7fffffff;
		else if (hd < -54'sd2147483648) h_n = 32'sh80000000;
		else h_n = 32'(hd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1 <= din.hit;
			ang_s1 <= ang_n;
			mag_s1 <= 36'((magp + 64'sd134217728) >>> 28);
			h_s1   <= h_n;
		end
	end

	// ---- stage 2: snap the angle into the arc range
	logic                 v_s2, hit_s2;
	logic signed [AW-1:0] tn_s2;
	logic signed [35:0]   mag_s2;
	logic signed [31:0]   h_s2;
	logic signed [AW-1:0] th, d0, d1, d0b, d1b, tn_n;
	logic                 in_rng;

	always_comb begin
		th     = AW'(ang_s1);
		in_rng = (th <= t1_q && t0_q <= th) || (t1_q < t0_q && (th <= t1_q || t0_q <= th));
		d0     = abs_a(th - t0_q);
		d0b    = abs_a(th - TWO_PI_Q - t0_q);
		d1     = abs_a(th - t1_q);
		d1b    = abs_a(th + TWO_PI_Q - t1_q);
		if (d0b < d0) d0 = d0b;
		if (d1b < d1) d1 = d1b;
		if (full_q || in_rng) tn_n = th;
		else if (d0 <= d1) tn_n = t0_q;
		else tn_n = t1_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s2 <= hit_s1;
			tn_s2  <= tn_n;
			mag_s2 <= mag_s1;
			h_s2   <= h_s1;
		end
	end

	// ---- stage 3: angle from arc start, clamped radial offset
	logic                 v_s3, hit_s3;
	logic signed [AW-1:0] dtn_s3;
	logic signed [31:0]   r_s3;
	logic signed [31:0]   h_s3;
	logic signed [AW-1:0] dtn_n;
	logic signed [36:0]   rr;
	logic signed [31:0]   r_n;

	always_comb begin
		dtn_n = (cfg.theta_span > 0) ? tn_s2 - t0_q : t1_q - tn_s2;
		if (dtn_n < 0) dtn_n = dtn_n + TWO_PI_Q;
		if (cfg.theta_span >= 0) rr = 37'($signed({1'b0, cfg.radius})) - 37'(mag_s2);
		else rr = 37'(mag_s2) - 37'($signed({1'b0, cfg.radius}));
		if (rr < 37'(cfg.offset_min)) rr = 37'(cfg.offset_min);
		if (rr > 37'(cfg.offset_max)) rr = 37'(cfg.offset_max);
		r_n = 32'(rr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s3 <= hit_s2;
			dtn_s3 <= dtn_n;
			r_s3   <= r_n;
			h_s3   <= h_s2;
		end
	end

	// ---- stage 4: arc length, output register
	logic signed [55:0] sprod;
	logic signed [39:0] s_w;
	res_t               res_n;

	always_comb begin
		sprod = 56'($signed({1'b0, cfg.radius})) * 56'(dtn_s3);
		s_w   = 40'((sprod + 56'sd32768) >>> 16);
		res_n.height = h_s3;
		res_n.center_hit = hit_s3;
		if (hit_s3) begin
			res_n.arc_length = '0;
			res_n.lateral_offset = '0;
		end else begin
			res_n.arc_length = (s_w > 40'sh007fffffff) ? 31'h7fffffff : 31'(s_w);
			res_n.lateral_offset = r_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_data <= res_n;
		end
	end

endmodule
`default_nettype wire

/* hdl/point_to_arc_lane_coordinates_core.sv */
// Path: pre-rotation register, the row of cells, then the back-end stages.
// Throughput: one point per cycle; the whole row of cells and the back end
// advance together and hold while a finished result is stalled.
// Reset: asynchronous, active low; clears all valid bits and loads the
// configuration registers with their reset values.
// ----------------------------------------------------------------------------
// point_to_arc_lane_coordinates_core
// Projects a 3D point onto arc-lane coordinates with a row of CORDIC cells.
// ----------------------------------------------------------------------------
`default_nettype none
module point_to_arc_lane_coordinates_core
	import ptac_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pt_valid,
	output logic             pt_stall,
	input  wire pt_t         pt_data,
	output logic             res_valid,
	input  wire logic        res_stall,
	output res_t             res_data,
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [31:0] cfg_wdata
);

	cfg_t cfg_q;
	logic en;

	// Advance unless the output register holds a stalled beat
	assign en = !(res_valid && res_stall);
	assign pt_stall = !en;

	// Configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x    <= '0;
			cfg_q.center_y    <= '0;
			cfg_q.radius      <= 31'd65536;
			cfg_q.theta_start <= '0;
			cfg_q.theta_span  <= 20'sd102944;
			cfg_q.offset_min  <= -32'sd65536;
			cfg_q.offset_max  <= 32'sd65536;
			cfg_q.elevation_a <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_idx))
				REG_CENTER_X:    cfg_q.center_x    <= cfg_wdata;
				REG_CENTER_Y:    cfg_q.center_y    <= cfg_wdata;
				REG_RADIUS:      cfg_q.radius      <= cfg_wdata[30:0];
				REG_THETA_START: cfg_q.theta_start <= cfg_wdata[19:0];
				REG_THETA_SPAN:  cfg_q.theta_span  <= cfg_wdata[19:0];
				REG_OFFSET_MIN:  cfg_q.offset_min  <= cfg_wdata;
				REG_OFFSET_MAX:  cfg_q.offset_max  <= cfg_wdata;
				REG_ELEVATION_A: cfg_q.elevation_a <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Offset from center, prescale, quarter-turn pre-rotation
	logic signed [32:0]   dx, dy;
	logic signed [XW-1:0] x0, y0;
	cell_t                pre_n;
	cell_t                chain [0:CORDIC_STEPS];

	always_comb begin
		dx = 33'(pt_data.pos_x) - 33'(cfg_q.center_x);
		dy = 33'(pt_data.pos_y) - 33'(cfg_q.center_y);
		x0 = XW'(dx) <<< 8;
		y0 = XW'(dy) <<< 8;
		pre_n.valid = pt_valid;
		pre_n.pz    = pt_data.pos_z;
		pre_n.hit   = (dx == 0) && (dy == 0);
		pre_n.x     = x0;
		pre_n.y     = y0;
		pre_n.z     = '0;
		if (x0 < 0) begin
			if (y0 >= 0) begin
				pre_n.x = y0;
				pre_n.y = -x0;
				pre_n.z = HALF_PI_Q30;
			end else begin
				pre_n.x = -y0;
				pre_n.y = x0;
				pre_n.z = -HALF_PI_Q30;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0] <= '0;
		end else if (en) begin
			chain[0] <= pre_n;
		end
	end

	// Row of CORDIC cells
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		ptac_cell #(.STEP(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	ptac_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.din       (chain[CORDIC_STEPS]),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

endmodule
`default_nettype wire

/* hdl/ptac_chk.sv */
// ----------------------------------------------------------------------------
// ptac_chk
// Port-level checks on the arc-lane projection core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module ptac_chk
	import ptac_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        pt_stall,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire res_t        res_data
);

	// Hold a stalled result beat
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result beat dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_data))
		else $error("stalled result beat changed");

	// Input stalls only behind a stalled result
	a_back_press: assert property (@(posedge clk) disable iff (!arst_n)
		pt_stall == (res_valid && res_stall))
		else $error("input stall does not track output stall");

	// Center hit zeroes the lane coordinates
	a_hit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.center_hit |->
		res_data.arc_length == 0 && res_data.lateral_offset == 0)
		else $error("center hit with nonzero coordinates");

endmodule

bind point_to_arc_lane_coordinates_core ptac_chk u_ptac_chk (.*);
`default_nettype wire

/* sim/point_to_arc_lane_coordinates_core_test.sv */
// ----------------------------------------------------------------------------
// point_to_arc_lane_coordinates_core_test
// Drives points through the arc-lane projection core at random rates, predicts
// each result in a bit-exact software model of the CORDIC datapath and checks
// every result beat in order, across several arc configurations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module point_to_arc_lane_coordinates_core_test;
	import ptac_pkg::*;

	localparam int STEPS = CORDIC_STEPS_DEF;
	localparam int LATENCY = STEPS + 5;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam longint PI_L = 205887;
	localparam longint TWO_PI_L = 411775;

	// Arc projection predictor with its own copy of the registers
	class arc_projection_board;
		cfg_t cfg;
		res_t pending[$];
		int errors;

		function void reset_regs();
			cfg.center_x = 0;
			cfg.center_y = 0;
			cfg.radius = 31'd65536;
			cfg.theta_start = 0;
			cfg.theta_span = 20'sd102944;
			cfg.offset_min = -32'sd65536;
			cfg.offset_max = 32'sd65536;
			cfg.elevation_a = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [31:0] v);
			case (idx)
				REG_CENTER_X:    cfg.center_x = v;
				REG_CENTER_Y:    cfg.center_y = v;
				REG_RADIUS:      cfg.radius = v[30:0];
				REG_THETA_START: cfg.theta_start = v[19:0];
				REG_THETA_SPAN:  cfg.theta_span = v[19:0];
				REG_OFFSET_MIN:  cfg.offset_min = v;
				REG_OFFSET_MAX:  cfg.offset_max = v;
				REG_ELEVATION_A: cfg.elevation_a = v;
				default: ;
			endcase
		endfunction

		function longint shr(longint v, int s);
			return v >>> s;
		endfunction

		function longint wrap2pi(longint t);
			longint r;
			r = t % TWO_PI_L;
			if (r < 0) r += TWO_PI_L;
			if (r > PI_L) r -= TWO_PI_L;
			return r;
		endfunction

		function longint atan_entry(int i);
			longint tab[32] = '{843314857, 497837829, 263043836, 133525158, 67021686,
				33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
				262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
				255, 127, 63, 31, 15, 7, 3, 1, 0, 0};
			return tab[i];
		endfunction

		function longint snap(longint th, longint tmin, longint tmax);
			longint t0, t1, d0, d1, a, b;
			if (tmax >= tmin + TWO_PI_L) return th;
			t0 = wrap2pi(tmin);
			t1 = wrap2pi(tmax);
			if (th <= t1 && t0 <= th) return th;
			if (t1 < t0 && (th <= t1 || t0 <= th)) return th;
			a = th - t0; if (a < 0) a = -a;
			b = th - TWO_PI_L - t0; if (b < 0) b = -b;
			d0 = a < b ? a : b;
			a = th - t1; if (a < 0) a = -a;
			b = th + TWO_PI_L - t1; if (b < 0) b = -b;
			d1 = a < b ? a : b;
			return (d0 <= d1) ? t0 : t1;
		endfunction

		function res_t project(pt_t p);
			res_t o;
			longint dx, dy, ts, tsp, rad, tmin, tmax, pscale, phi, plo, elev, h;
			longint x, y, z, t, sx, sy, ang, mag, tn, dtn, s, r;
			dx = longint'(p.pos_x) - longint'(cfg.center_x);
			dy = longint'(p.pos_y) - longint'(cfg.center_y);
			ts = cfg.theta_start;
			tsp = cfg.theta_span;
			rad = longint'({1'b0, cfg.radius});
			tmin = (ts < ts + tsp) ? ts : ts + tsp;
			tmax = (ts > ts + tsp) ? ts : ts + tsp;
			pscale = shr(rad * tsp + 32768, 16);
			phi = shr(pscale, 16);
			plo = pscale & 64'hFFFF;
			elev = longint'(cfg.elevation_a) * phi
				+ shr(longint'(cfg.elevation_a) * plo + 32768, 16);
			h = longint'(p.pos_z) - elev;
			if (h < -64'sd2147483648) h = -64'sd2147483648;
			if (h > 64'sd2147483647) h = 64'sd2147483647;
			s = 0;
			r = 0;
			o.center_hit = (dx == 0 && dy == 0);
			if (!o.center_hit) begin
				x = dx * 256;
				y = dy * 256;
				z = 0;
				// quarter-turn pre-rotation into the right half plane
				if (x < 0) begin
					if (y >= 0) begin
						t = y; y = -x; x = t; z = 1686629713;
					end else begin
						t = -y; y = x; x = t; z = -1686629713;
					end
				end
				for (int i = 0; i < STEPS; i++) begin
					sy = shr(y, i);
					sx = shr(x, i);
					if (y < 0) begin
						x -= sy; y += sx; z -= atan_entry(i);
					end else begin
						x += sy; y -= sx; z += atan_entry(i);
					end
				end
				ang = shr(z + 8192, 14);
				if (ang < -PI_L) ang = -PI_L;
				if (ang > PI_L) ang = PI_L;
				mag = (x * 636751 + (64'sd1 << 27)) >>> 28;
				tn = snap(ang, tmin, tmax);
				dtn = (tsp > 0) ? tn - wrap2pi(tmin) : wrap2pi(tmax) - tn;
				if (dtn < 0) dtn += TWO_PI_L;
				s = (rad * dtn + 32768) >>> 16;
				if (s > 64'h7FFFFFFF) s = 64'h7FFFFFFF;
				r = (tsp >= 0) ? rad - mag : mag - rad;
				if (r < longint'(cfg.offset_min)) r = cfg.offset_min;
				if (r > longint'(cfg.offset_max)) r = cfg.offset_max;
			end
			o.arc_length = s[30:0];
			o.lateral_offset = r[31:0];
			o.height = h[31:0];
			return o;
		endfunction

		// Print one mismatch line and count it
		task report_mismatch(string what, longint got, longint want);
			$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want,
				$realtime);
			errors++;
		endtask

		function void note_point(pt_t p);
			pending.push_back(project(p));
		endfunction

		task check_result(res_t got);
			res_t exp_r;
			if (pending.size() == 0) begin
				report_mismatch("result beat with nothing pending", 0, 0);
				return;
			end
			exp_r = pending.pop_front();
			if (got.center_hit !== exp_r.center_hit)
				report_mismatch("center_hit", got.center_hit, exp_r.center_hit);
			if (got.arc_length !== exp_r.arc_length)
				report_mismatch("arc_length", got.arc_length, exp_r.arc_length);
			if (got.lateral_offset !== exp_r.lateral_offset)
				report_mismatch("lateral_offset", got.lateral_offset,
					exp_r.lateral_offset);
			if (got.height !== exp_r.height)
				report_mismatch("height", got.height, exp_r.height);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pt_valid = 1'b0;
	logic pt_stall;
	pt_t pt_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_data;
	logic cfg_wr_en = 1'b0;
	logic [2:0] cfg_idx = '0;
	logic [31:0] cfg_wdata = '0;

	int idle_cycles = 0;
	bit hold_off = 1'b0;
	arc_projection_board board;

	point_to_arc_lane_coordinates_core dut (
		.clk(clk), .arst_n(arst_n),
		.pt_valid(pt_valid), .pt_stall(pt_stall), .pt_data(pt_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
		.cfg_wr_en(cfg_wr_en), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (pt_valid && !pt_stall) board.note_point(pt_data);
			if (res_valid && !res_stall) board.check_result(res_data);
			if ((pt_valid && !pt_stall) || (res_valid && !res_stall)) idle_cycles = 0;
			else idle_cycles++;
		end
	end

	// Receiver: random stalls per beat, or a long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				res_stall <= 1'b1;
				for (int i = 0; i < 3 * LATENCY; i++) @(negedge clk);
				res_stall <= 1'b0;
				hold_off = 1'b0;
			end else if (res_valid && !res_stall) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
				if (gap == 0) res_stall <= 1'b0;
				else begin
					res_stall <= 1'b1;
					for (int i = 1; i < gap; i++) @(negedge clk);
					@(negedge clk);
					res_stall <= 1'b0;
				end
			end
		end
	end

	// Offer one beat after an optional gap; valid stays up for a following beat
	task automatic send_point(pt_t p, int gap);
		if (gap > 0) begin
			pt_valid <= 1'b0;
			for (int i = 0; i < gap; i++) @(negedge clk);
		end
		pt_valid <= 1'b1;
		pt_data <= p;
		@(posedge clk);
		while (pt_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_burst(pt_t p);
		pt_valid <= 1'b1;
		pt_data <= p;
		@(posedge clk);
		while (pt_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		pt_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		for (int i = 0; i < LATENCY + 4; i++) @(negedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t idx, logic [31:0] v);
		cfg_wr_en <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		board.write_reg(idx, v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_angle();
		return 32'(int'($urandom_range(0, 823550)) - 411775);
	endfunction

	function automatic pt_t rand_point(int mode);
		pt_t p;
		case (mode)
			0: begin
				p.pos_x = $urandom;
				p.pos_y = $urandom;
			end
			1: begin
				p.pos_x = board.cfg.center_x + 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
				p.pos_y = board.cfg.center_y + 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
			end
			default: begin
				p.pos_x = board.cfg.center_x + 32'(int'($urandom_range(0, 8)) - 4);
				p.pos_y = board.cfg.center_y + 32'(int'($urandom_range(0, 8)) - 4);
			end
		endcase
		p.pos_z = $urandom;
		return p;
	endfunction

	task automatic random_config(int kind);
		write_cfg(REG_CENTER_X, (kind == 0) ? $urandom : 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23)));
		write_cfg(REG_CENTER_Y, (kind == 0) ? $urandom : 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23)));
		write_cfg(REG_RADIUS, (kind == 1) ? 32'h7FFFFFFF : (kind == 2) ? 32'd1 : $urandom_range(1, 1 << 22));
		write_cfg(REG_THETA_START, (kind == 1) ? 32'd411775 : (kind == 2) ? -32'sd411775 : rand_angle());
		write_cfg(REG_THETA_SPAN, (kind == 1) ? -32'sd411775 : (kind == 2) ? 32'd0 : rand_angle());
		write_cfg(REG_OFFSET_MIN, (kind == 1) ? 32'h80000000 : $urandom);
		write_cfg(REG_OFFSET_MAX, (kind == 1) ? 32'h7FFFFFFF : $urandom);
		write_cfg(REG_ELEVATION_A, (kind == 1) ? 32'h80000000 : (kind == 2) ? 32'h7FFFFFFF : $urandom);
	endtask

	// Watchdog on cycles with no beat accepted
	initial begin
		forever begin
			@(posedge clk);
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("point_to_arc_lane_coordinates_core test failed");
				$finish;
			end
		end
	end

	initial begin
		pt_t p;
		board = new();
		board.reset_regs();
		board.errors = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, center hit, axis directions, reset config
		p = '{pos_x: 0, pos_y: 0, pos_z: 32'h7FFFFFFF};
		send_point(p, 0);
		p = '{pos_x: 32'h80000000, pos_y: 32'h80000000, pos_z: 32'h80000000};
		send_point(p, 1);
		p = '{pos_x: 32'h7FFFFFFF, pos_y: 32'h7FFFFFFF, pos_z: 0};
		send_point(p, 0);
		p = '{pos_x: 32'h80000000, pos_y: 32'h7FFFFFFF, pos_z: 1};
		send_point(p, 2);
		p = '{pos_x: 32'h7FFFFFFF, pos_y: 32'h80000000, pos_z: -1};
		send_point(p, 0);
		p = '{pos_x: -65536, pos_y: 0, pos_z: 0};
		send_point(p, 0);
		p = '{pos_x: -65536, pos_y: -1, pos_z: 0};
		send_point(p, 0);
		p = '{pos_x: 0, pos_y: -65536, pos_z: 0};
		send_point(p, 0);
		p = '{pos_x: 65536, pos_y: 65536, pos_z: 0};
		send_point(p, 0);
		drain();
		// Inverted bounds, negative sweep, zero radius corner
		write_cfg(REG_OFFSET_MIN, 32'd100000);
		write_cfg(REG_OFFSET_MAX, -32'sd100000);
		write_cfg(REG_THETA_SPAN, -32'sd300000);
		write_cfg(REG_ELEVATION_A, 32'h7FFFFFFF);
		p = '{pos_x: 65536, pos_y: -65536, pos_z: 32'h80000000};
		send_point(p, 0);
		p = '{pos_x: -3, pos_y: 2, pos_z: 5};
		send_point(p, 0);
		p = '{pos_x: 0, pos_y: 0, pos_z: 5};
		send_point(p, 0);
		drain();
		write_cfg(REG_RADIUS, 32'd0);
		write_cfg(REG_THETA_SPAN, 32'd0);
		p = '{pos_x: 65536, pos_y: 65536, pos_z: 5};
		send_point(p, 0);
		p = '{pos_x: -65536, pos_y: 65536, pos_z: 5};
		send_point(p, 0);
		drain();

		// Random phases over several configurations
		for (int ph = 0; ph < 10; ph++) begin
			random_config(ph < 3 ? ph : 3);
			if (ph == 4) begin
				// fill the pipe while the receiver holds off
				hold_off = 1'b1;
				for (int i = 0; i < 2 * LATENCY; i++) send_burst(rand_point($urandom_range(0, 2)));
			end
			for (int i = 0; i < 100; i++) begin
				if ($urandom_range(0, 4) == 0)
					send_point(rand_point($urandom_range(0, 2)), 0);
				else
					send_point(rand_point($urandom_range(0, 2)), $urandom_range(0, 5));
			end
			drain();
		end

		while (board.pending.size() != 0) @(negedge clk);
		for (int i = 0; i < LATENCY + 4; i++) @(negedge clk);
		if (board.errors == 0)
			$display("point_to_arc_lane_coordinates_core test passed");
		else
			$display("point_to_arc_lane_coordinates_core test failed");
		$finish;
	end
endmodule
`default_nettype wire
